[hdl/segi_pkg.sv]
// Shared constants and types for the segment intersection test.
package segi_pkg;

   // Default coordinate width: signed fixed point with 12 integer, 4 fraction bits.
   localparam int COORD_BITS_DEFAULT = 16;

   // Number of orientation tests per segment pair.
   localparam int NUM_ORIENT = 4;

   // Orientation of a point triple, taken from the sign of a cross product.
   typedef enum logic [1:0] {
      ORIENT_COLLINEAR = 2'd0,
      ORIENT_POSITIVE  = 2'd1,
      ORIENT_NEGATIVE  = 2'd2
   } orient_type;

   // Per-stage handshake control handed from the top level to a stage.
   typedef struct packed {
      logic load;
   } stage_ctl_type;

endpackage

[hdl/segi_if.sv]
// Handshake channel interfaces for segment pairs and intersection results.
interface segi_req_if #(
   parameter int COORD_BITS = segi_pkg::COORD_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] a_start_x;
   logic signed [COORD_BITS-1:0] a_start_y;
   logic signed [COORD_BITS-1:0] a_end_x;
   logic signed [COORD_BITS-1:0] a_end_y;
   logic signed [COORD_BITS-1:0] b_start_x;
   logic signed [COORD_BITS-1:0] b_start_y;
   logic signed [COORD_BITS-1:0] b_end_x;
   logic signed [COORD_BITS-1:0] b_end_y;

   modport source (
      output valid, a_start_x, a_start_y, a_end_x, a_end_y,
             b_start_x, b_start_y, b_end_x, b_end_y,
      input  ready
   );
   modport sink (
      input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
             b_start_x, b_start_y, b_end_x, b_end_y,
      output ready
   );
endinterface

interface segi_rsp_if;
   logic valid;
   logic ready;
   logic intersects;

   modport source (output valid, intersects, input ready);
   modport sink (input valid, intersects, output ready);
endinterface

[hdl/segment_intersection_test.sv]
// Top level of the segment intersection test: stage control and the result register.
// Takes one segment pair per beat and answers whether the two closed segments share a
// point, touching and collinear overlap included. A pair can be accepted in every
// cycle while the pipeline is not stalled, and its result appears on the response
// channel from the last of four register stages, the first loaded at the accepting edge:
// the coordinate differences and box checks, the cross-product multipliers, the product
// subtraction and sign, and the final decision held in the output register. Each stage
// holds its beat while the one after it cannot take it, so a stall on the response side
// backs up through the pipeline without losing or repeating a beat.
module segment_intersection_test #(
   parameter int COORD_BITS = segi_pkg::COORD_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   segi_req_if.sink       req_bus,
   segi_rsp_if.source     rsp_bus
);

   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int NO = segi_pkg::NUM_ORIENT;

   logic valid1_ff, valid2_ff, valid3_ff, valid4_ff;
   logic valid1_in, valid2_in, valid3_in, valid4_in;
   logic ready1, ready2, ready3, ready4;
   segi_pkg::stage_ctl_type ctl1, ctl2, ctl3;

   logic signed [DW-1:0] a_d [NO];
   logic signed [DW-1:0] b_d [NO];
   logic signed [DW-1:0] c_d [NO];
   logic signed [DW-1:0] d_d [NO];
   logic [NO-1:0]        box1, box2, box3;
   logic signed [PW-1:0] ab_p [NO];
   logic signed [PW-1:0] cd_p [NO];
   segi_pkg::orient_type orient [NO];

   logic hit;
   logic hit_ff, hit_in;

   // A stage takes a new beat when it is empty or its beat moves on this cycle.
   always_comb begin
      ready4 = !valid4_ff || rsp_bus.ready;
      ready3 = !valid3_ff || ready4;
      ready2 = !valid2_ff || ready3;
      ready1 = !valid1_ff || ready2;
      ctl1.load = ready1;
      ctl2.load = ready2;
      ctl3.load = ready3;
      valid1_in = ready1 ? req_bus.valid : valid1_ff;
      valid2_in = ready2 ? valid1_ff     : valid2_ff;
      valid3_in = ready3 ? valid2_ff     : valid3_ff;
      valid4_in = ready4 ? valid3_ff     : valid4_ff;
   end

   assign req_bus.ready = ready1;

   segi_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock     (clock),
      .ctl       (ctl1),
      .a_start_x (req_bus.a_start_x),
      .a_start_y (req_bus.a_start_y),
      .a_end_x   (req_bus.a_end_x),
      .a_end_y   (req_bus.a_end_y),
      .b_start_x (req_bus.b_start_x),
      .b_start_y (req_bus.b_start_y),
      .b_end_x   (req_bus.b_end_x),
      .b_end_y   (req_bus.b_end_y),
      .a_ff      (a_d),
      .b_ff      (b_d),
      .c_ff      (c_d),
      .d_ff      (d_d),
      .box_ff    (box1)
   );

   segi_prod #(.COORD_BITS(COORD_BITS)) u_prod (
      .clock  (clock),
      .ctl    (ctl2),
      .a_q    (a_d),
      .b_q    (b_d),
      .c_q    (c_d),
      .d_q    (d_d),
      .box_q  (box1),
      .ab_ff  (ab_p),
      .cd_ff  (cd_p),
      .box_ff (box2)
   );

   segi_sign #(.COORD_BITS(COORD_BITS)) u_sign (
      .clock     (clock),
      .ctl       (ctl3),
      .ab_q      (ab_p),
      .cd_q      (cd_p),
      .box_q     (box2),
      .orient_ff (orient),
      .box_ff    (box3)
   );

   // General crossing when each segment's endpoints straddle the other's line;
   // otherwise a collinear endpoint counts only if it sits inside the other box.
   always_comb begin
      hit = ((orient[0] != orient[1]) && (orient[2] != orient[3]))
            || ((orient[0] == segi_pkg::ORIENT_COLLINEAR) && box3[0])
            || ((orient[1] == segi_pkg::ORIENT_COLLINEAR) && box3[1])
            || ((orient[2] == segi_pkg::ORIENT_COLLINEAR) && box3[2])
            || ((orient[3] == segi_pkg::ORIENT_COLLINEAR) && box3[3]);
      hit_in = ready4 ? hit : hit_ff;
   end

   always_ff @(posedge clock) begin
      hit_ff <= hit_in;
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         valid4_ff <= 1'b0;
      end else begin
         valid1_ff <= valid1_in;
         valid2_ff <= valid2_in;
         valid3_ff <= valid3_in;
         valid4_ff <= valid4_in;
      end
   end

   assign rsp_bus.valid      = valid4_ff;
   assign rsp_bus.intersects = hit_ff;

endmodule

[hdl/segi_front.sv]
// First stage: coordinate differences for the cross products and bounding-box checks.
module segi_front #(
   parameter int COORD_BITS = segi_pkg::COORD_BITS_DEFAULT,
   localparam int DW = COORD_BITS + 1
) (
   input  logic                           clock,
   input  segi_pkg::stage_ctl_type        ctl,
   input  logic signed [COORD_BITS-1:0]   a_start_x,
   input  logic signed [COORD_BITS-1:0]   a_start_y,
   input  logic signed [COORD_BITS-1:0]   a_end_x,
   input  logic signed [COORD_BITS-1:0]   a_end_y,
   input  logic signed [COORD_BITS-1:0]   b_start_x,
   input  logic signed [COORD_BITS-1:0]   b_start_y,
   input  logic signed [COORD_BITS-1:0]   b_end_x,
   input  logic signed [COORD_BITS-1:0]   b_end_y,
   output logic signed [DW-1:0]           a_ff [segi_pkg::NUM_ORIENT],
   output logic signed [DW-1:0]           b_ff [segi_pkg::NUM_ORIENT],
   output logic signed [DW-1:0]           c_ff [segi_pkg::NUM_ORIENT],
   output logic signed [DW-1:0]           d_ff [segi_pkg::NUM_ORIENT],
   output logic [segi_pkg::NUM_ORIENT-1:0] box_ff
);

   logic signed [DW-1:0] a_in [segi_pkg::NUM_ORIENT];
   logic signed [DW-1:0] b_in [segi_pkg::NUM_ORIENT];
   logic signed [DW-1:0] c_in [segi_pkg::NUM_ORIENT];
   logic signed [DW-1:0] d_in [segi_pkg::NUM_ORIENT];
   logic [segi_pkg::NUM_ORIENT-1:0] box_in;

   function automatic logic signed [DW-1:0] diff(
      input logic signed [COORD_BITS-1:0] hi,
      input logic signed [COORD_BITS-1:0] lo
   );
      diff = $signed({hi[COORD_BITS-1], hi}) - $signed({lo[COORD_BITS-1], lo});
   endfunction

   // True when q lies between p and r on one axis, ends included, in either order.
   function automatic logic between(
      input logic signed [COORD_BITS-1:0] p,
      input logic signed [COORD_BITS-1:0] q,
      input logic signed [COORD_BITS-1:0] r
   );
      between = ((p <= q) && (q <= r)) || ((r <= q) && (q <= p));
   endfunction

   // Cross product of orientation (p, q, r) is a*b - c*d with
   // a = qy-py, b = rx-qx, c = qx-px, d = ry-qy.
   always_comb begin
      a_in[0] = diff(a_end_y, a_start_y);
      b_in[0] = diff(b_start_x, a_end_x);
      c_in[0] = diff(a_end_x, a_start_x);
      d_in[0] = diff(b_start_y, a_end_y);

      a_in[1] = diff(a_end_y, a_start_y);
      b_in[1] = diff(b_end_x, a_end_x);
      c_in[1] = diff(a_end_x, a_start_x);
      d_in[1] = diff(b_end_y, a_end_y);

      a_in[2] = diff(b_end_y, b_start_y);
      b_in[2] = diff(a_start_x, b_end_x);
      c_in[2] = diff(b_end_x, b_start_x);
      d_in[2] = diff(a_start_y, b_end_y);

      a_in[3] = diff(b_end_y, b_start_y);
      b_in[3] = diff(a_end_x, b_end_x);
      c_in[3] = diff(b_end_x, b_start_x);
      d_in[3] = diff(a_end_y, b_end_y);

      box_in[0] = between(a_start_x, b_start_x, a_end_x)
                  && between(a_start_y, b_start_y, a_end_y);
      box_in[1] = between(a_start_x, b_end_x, a_end_x)
                  && between(a_start_y, b_end_y, a_end_y);
      box_in[2] = between(b_start_x, a_start_x, b_end_x)
                  && between(b_start_y, a_start_y, b_end_y);
      box_in[3] = between(b_start_x, a_end_x, b_end_x)
                  && between(b_start_y, a_end_y, b_end_y);
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         a_ff   <= a_in;
         b_ff   <= b_in;
         c_ff   <= c_in;
         d_ff   <= d_in;
         box_ff <= box_in;
      end
   end

endmodule

[hdl/segi_prod.sv]
// Second stage: the eight full-width products of the four cross products.
module segi_prod #(
   parameter int COORD_BITS = segi_pkg::COORD_BITS_DEFAULT,
   localparam int DW = COORD_BITS + 1,
   localparam int PW = 2 * DW
) (
   input  logic                           clock,
   input  segi_pkg::stage_ctl_type        ctl,
   input  logic signed [DW-1:0]           a_q [segi_pkg::NUM_ORIENT],
   input  logic signed [DW-1:0]           b_q [segi_pkg::NUM_ORIENT],
   input  logic signed [DW-1:0]           c_q [segi_pkg::NUM_ORIENT],
   input  logic signed [DW-1:0]           d_q [segi_pkg::NUM_ORIENT],
   input  logic [segi_pkg::NUM_ORIENT-1:0] box_q,
   output logic signed [PW-1:0]           ab_ff [segi_pkg::NUM_ORIENT],
   output logic signed [PW-1:0]           cd_ff [segi_pkg::NUM_ORIENT],
   output logic [segi_pkg::NUM_ORIENT-1:0] box_ff
);

   logic signed [PW-1:0] ab_in [segi_pkg::NUM_ORIENT];
   logic signed [PW-1:0] cd_in [segi_pkg::NUM_ORIENT];

   always_comb begin
      for (int i = 0; i < segi_pkg::NUM_ORIENT; i++) begin
         ab_in[i] = PW'(a_q[i] * b_q[i]);
         cd_in[i] = PW'(c_q[i] * d_q[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         ab_ff  <= ab_in;
         cd_ff  <= cd_in;
         box_ff <= box_q;
      end
   end

endmodule

[hdl/segi_sign.sv]
// Third stage: exact product difference and its sign as an orientation code.
module segi_sign #(
   parameter int COORD_BITS = segi_pkg::COORD_BITS_DEFAULT,
   localparam int DW = COORD_BITS + 1,
   localparam int PW = 2 * DW,
   localparam int SW = PW + 1
) (
   input  logic                           clock,
   input  segi_pkg::stage_ctl_type        ctl,
   input  logic signed [PW-1:0]           ab_q [segi_pkg::NUM_ORIENT],
   input  logic signed [PW-1:0]           cd_q [segi_pkg::NUM_ORIENT],
   input  logic [segi_pkg::NUM_ORIENT-1:0] box_q,
   output segi_pkg::orient_type           orient_ff [segi_pkg::NUM_ORIENT],
   output logic [segi_pkg::NUM_ORIENT-1:0] box_ff
);

   logic signed [SW-1:0] xprod [segi_pkg::NUM_ORIENT];
   segi_pkg::orient_type orient_in [segi_pkg::NUM_ORIENT];

   always_comb begin
      for (int i = 0; i < segi_pkg::NUM_ORIENT; i++) begin
         xprod[i] = $signed({ab_q[i][PW-1], ab_q[i]}) - $signed({cd_q[i][PW-1], cd_q[i]});
         if (xprod[i] == '0) begin
            orient_in[i] = segi_pkg::ORIENT_COLLINEAR;
         end else if (xprod[i][SW-1]) begin
            orient_in[i] = segi_pkg::ORIENT_NEGATIVE;
         end else begin
            orient_in[i] = segi_pkg::ORIENT_POSITIVE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         orient_ff <= orient_in;
         box_ff    <= box_q;
      end
   end

endmodule
